// ===== rtl/core/fbdr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbdr_pkg
// Shared types and constants for the frame store with dirty-row flush.
// ----------------------------------------------------------------------------
package fbdr_pkg;

    localparam int SCREEN_HEIGHT = 64;
    localparam int ROW_BITS      = 128;
    localparam int ROW_AW        = 6;
    localparam int NUM_ROWS      = 64;

    localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(SCREEN_HEIGHT - 1);

    localparam logic [7:0] ROW_CMD_BASE = 8'h80;
    localparam logic [7:0] COL_CMD_TOP  = 8'h80;
    localparam logic [7:0] COL_CMD_BOT  = 8'h88;

    typedef enum logic [2:0] {
        CMD_PIXEL   = 3'd0,
        CMD_FILL    = 3'd1,
        CMD_OUTLINE = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_RAW     = 3'd4,
        CMD_FLUSH   = 3'd5
    } t_cmd;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] width;
        logic [15:0] height;
        logic        pixel_on;
        logic [9:0]  byte_index;
        logic [7:0]  byte_value;
    } t_in_word;

    typedef struct packed {
        logic        row_valid;
        logic [5:0]  screen_row;
        logic [7:0]  row_address_command;
        logic [7:0]  column_address_command;
        logic [63:0] pixels_left;
        logic [63:0] pixels_right;
        logic        last;
    } t_out_word;

    typedef struct packed {
        logic [ROW_BITS-1:0] fill;
        logic [ROW_BITS-1:0] edge_cols;
        logic [ROW_BITS-1:0] side;
    } t_col_masks;

endpackage

// ===== rtl/core/fbdr_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbdr_ram
// One row-wide synchronous memory, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module fbdr_ram (
    input  logic                          i_clk,
    input  logic                          i_wr_en,
    input  logic                          i_rd_en,
    input  logic [fbdr_pkg::ROW_AW-1:0]   i_addr,
    input  logic [fbdr_pkg::ROW_BITS-1:0] i_wr_data,
    output logic [fbdr_pkg::ROW_BITS-1:0] o_rd_data
);

    logic [fbdr_pkg::ROW_BITS-1:0] mem [fbdr_pkg::NUM_ROWS];
    logic [fbdr_pkg::ROW_BITS-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/fbdr_colmask.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbdr_colmask
// Column masks of a rectangle: fill span, outline top/bottom span, side columns.
// ----------------------------------------------------------------------------
module fbdr_colmask (
    input  logic [15:0]           i_x,
    input  logic [15:0]           i_w,
    output fbdr_pkg::t_col_masks  o_masks
);

    logic signed [16:0] w_ext;
    assign w_ext = $signed({i_w[15], i_w});

    for (genvar c = 0; c < fbdr_pkg::ROW_BITS; c++) begin : g_col
        logic [15:0] dc;
        assign dc = 16'(c) - i_x;
        // column c sits at bit 127-c, leftmost pixel in the top bit
        assign o_masks.fill[fbdr_pkg::ROW_BITS-1-c] =
            $signed({1'b0, dc}) <= (w_ext - 17'sd1);
        assign o_masks.edge_cols[fbdr_pkg::ROW_BITS-1-c] = $signed({1'b0, dc}) <= w_ext;
        assign o_masks.side[fbdr_pkg::ROW_BITS-1-c] = (dc == 16'd0) || (dc == i_w);
    end

endmodule

// ===== rtl/core/framebuffer_dirty_row_flush.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framebuffer_dirty_row_flush
// 128x64 one-bit frame store with a shown copy and dirty-row flush.
// ----------------------------------------------------------------------------
// Both stores are row-wide memories (16 bytes per row) with a registered read;
// a valid bit per row makes an unwritten row read as zero, so reset and
// clear-frame take effect at once. One word is worked on at a time. A pixel
// or raw byte write steps through accept, read and write back; clear frame
// and ignored words are only accepted. Fill and outline walk every row with a
// read-modify-write. A flush reads and compares one row at a time and waits
// while the output side stalls; one changed row is held back so the final
// one can carry last.
module framebuffer_dirty_row_flush (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fbdr_pkg::t_in_word   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fbdr_pkg::t_out_word  o_out
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_WR   = 6'b000100,
        S_FRD  = 6'b001000,
        S_FCMP = 6'b010000,
        S_FEND = 6'b100000
    } t_state;

    localparam int RB = fbdr_pkg::ROW_BITS;

    t_state                      r_state, n_state;
    logic                        r_gfx_en;
    fbdr_pkg::t_cmd              r_cmd;
    logic [15:0]                 r_x, r_y, r_h;
    logic                        r_on;
    logic [9:0]                  r_bidx;
    logic [7:0]                  r_bval;
    fbdr_pkg::t_col_masks        r_masks;
    fbdr_pkg::t_col_masks        masks;
    logic [fbdr_pkg::ROW_AW-1:0] r_row;
    logic [fbdr_pkg::NUM_ROWS-1:0] r_fvalid, r_svalid;
    logic                        r_fv, r_sv;
    logic                        r_pend_v;
    logic [fbdr_pkg::ROW_AW-1:0] r_pend_row;
    logic [RB-1:0]               r_pend_data;
    logic                        r_o_valid;
    fbdr_pkg::t_out_word         r_out;

    logic [RB-1:0] f_rd, s_rd, f_old, s_old, f_new, row_mask, pix_mask;
    logic [RB-1:0] byte_mask, byte_data;
    logic          f_wr, f_rd_en, s_wr, s_rd_en;
    logic [15:0]   dr;
    logic signed [16:0] hm1;
    logic          fill_row, edge_row, side_row, pix_ok;
    logic          accept, differ, emit_ok, last_row;
    fbdr_pkg::t_cmd in_cmd;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign accept      = i_in_valid && (r_state == S_IDLE);
    assign in_cmd      = fbdr_pkg::t_cmd'(i_in.cmd);
    assign o_out_valid = r_o_valid;
    assign o_out       = r_out;

    fbdr_colmask u_colmask (
        .i_x     (i_in.x),
        .i_w     (i_in.width),
        .o_masks (masks)
    );

    fbdr_ram u_frame (
        .i_clk     (i_clk),
        .i_wr_en   (f_wr),
        .i_rd_en   (f_rd_en),
        .i_addr    (r_row),
        .i_wr_data (f_new),
        .o_rd_data (f_rd)
    );

    fbdr_ram u_shown (
        .i_clk     (i_clk),
        .i_wr_en   (s_wr),
        .i_rd_en   (s_rd_en),
        .i_addr    (r_row),
        .i_wr_data (f_old),
        .o_rd_data (s_rd)
    );

    // per-row span tests, offsets wrap to 16 bits
    assign dr       = {10'd0, r_row} - r_y;
    assign hm1      = $signed({r_h[15], r_h}) - 17'sd1;
    assign fill_row = $signed({1'b0, dr}) <= hm1;
    assign edge_row = (dr == 16'd0) || (dr == r_h);
    assign side_row = (dr != 16'd0) && ($signed({1'b0, dr}) <= hm1);

    assign pix_ok = !i_in.x[15] && (i_in.x[14:7] == 8'd0) && !i_in.y[15]
                  && (i_in.y < 16'(fbdr_pkg::SCREEN_HEIGHT));

    assign f_old = f_rd & {RB{r_fv}};
    assign s_old = s_rd & {RB{r_sv}};

    assign pix_mask  = {1'b1, {(RB-1){1'b0}}} >> r_x[6:0];
    assign byte_mask = {8'hFF, {(RB-8){1'b0}}} >> {r_bidx[3:0], 3'b000};
    assign byte_data = {r_bval, {(RB-8){1'b0}}} >> {r_bidx[3:0], 3'b000};

    always_comb begin
        case (r_cmd)
            fbdr_pkg::CMD_PIXEL:   row_mask = pix_mask;
            fbdr_pkg::CMD_FILL:    row_mask = fill_row ? r_masks.fill : '0;
            fbdr_pkg::CMD_OUTLINE: row_mask = (edge_row ? r_masks.edge_cols : '0)
                                            | (side_row ? r_masks.side : '0);
            default:               row_mask = '0;
        endcase
        if (r_cmd == fbdr_pkg::CMD_RAW) begin
            f_new = (f_old & ~byte_mask) | byte_data;
        end else if (r_on) begin
            f_new = f_old | row_mask;
        end else begin
            f_new = f_old & ~row_mask;
        end
    end

    assign differ   = (f_old != s_old);
    assign emit_ok  = !(r_pend_v && r_o_valid);
    assign last_row = (r_row == fbdr_pkg::LAST_ROW);

    assign f_rd_en = (r_state == S_RD) || (r_state == S_FRD);
    assign s_rd_en = (r_state == S_FRD);
    assign f_wr    = (r_state == S_WR);
    assign s_wr    = (r_state == S_FCMP) && differ && emit_ok;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (in_cmd)
                        fbdr_pkg::CMD_PIXEL:   n_state = pix_ok ? S_RD : S_IDLE;
                        fbdr_pkg::CMD_FILL:    n_state = S_RD;
                        fbdr_pkg::CMD_OUTLINE: n_state = S_RD;
                        fbdr_pkg::CMD_RAW:     n_state = r_gfx_en ? S_RD : S_IDLE;
                        fbdr_pkg::CMD_FLUSH:   n_state = r_gfx_en ? S_FRD : S_FEND;
                        default:               n_state = S_IDLE;
                    endcase
                end
            end
            S_RD: n_state = S_WR;
            S_WR: begin
                if ((r_cmd == fbdr_pkg::CMD_FILL || r_cmd == fbdr_pkg::CMD_OUTLINE)
                        && !last_row) begin
                    n_state = S_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_FRD: n_state = S_FCMP;
            S_FCMP: begin
                if (!differ || emit_ok) begin
                    n_state = last_row ? S_FEND : S_FRD;
                end
            end
            S_FEND: n_state = r_o_valid ? S_FEND : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_gfx_en  <= 1'b0;
            r_fvalid  <= '0;
            r_svalid  <= '0;
            r_pend_v  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_gfx_en <= i_cfg_data;
            end
            if (accept && in_cmd == fbdr_pkg::CMD_CLEAR) begin
                r_fvalid <= '0;
            end
            if (f_wr) begin
                r_fvalid[r_row] <= 1'b1;
            end
            if (s_wr) begin
                r_svalid[r_row] <= 1'b1;
                r_pend_v        <= 1'b1;
            end
            if (r_o_valid && !i_out_stall) begin
                r_o_valid <= 1'b0;
            end
            if (s_wr && r_pend_v) begin
                r_o_valid <= 1'b1;
            end
            if (r_state == S_FEND && !r_o_valid) begin
                r_o_valid <= 1'b1;
                r_pend_v  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd   <= in_cmd;
            r_x     <= i_in.x;
            r_y     <= i_in.y;
            r_h     <= i_in.height;
            r_on    <= i_in.pixel_on;
            r_bidx  <= i_in.byte_index;
            r_bval  <= i_in.byte_value;
            r_masks <= masks;
            if (in_cmd == fbdr_pkg::CMD_PIXEL) begin
                r_row <= i_in.y[fbdr_pkg::ROW_AW-1:0];
            end else if (in_cmd == fbdr_pkg::CMD_RAW) begin
                r_row <= i_in.byte_index[9:4];
            end else begin
                r_row <= '0;
            end
        end else if ((r_state == S_WR && !last_row)
                  || (r_state == S_FCMP && (!differ || emit_ok) && !last_row)) begin
            r_row <= r_row + 1'b1;
        end
        if (f_rd_en) begin
            r_fv <= r_fvalid[r_row];
            r_sv <= r_svalid[r_row];
        end
        if (s_wr) begin
            r_pend_row  <= r_row;
            r_pend_data <= f_old;
        end
        // pushing a held row out: last only when the flush ends
        if ((s_wr && r_pend_v) || (r_state == S_FEND && !r_o_valid)) begin
            if (r_pend_v) begin
                r_out.row_valid              <= 1'b1;
                r_out.screen_row             <= r_pend_row;
                r_out.row_address_command    <= fbdr_pkg::ROW_CMD_BASE | {3'd0, r_pend_row[4:0]};
                r_out.column_address_command <= r_pend_row[5] ? fbdr_pkg::COL_CMD_BOT
                                                              : fbdr_pkg::COL_CMD_TOP;
                r_out.pixels_left            <= r_pend_data[RB-1:64];
                r_out.pixels_right           <= r_pend_data[63:0];
                r_out.last                   <= (r_state == S_FEND);
            end else begin
                // bare done marker: all fields zero but last
                r_out <= {{($bits(fbdr_pkg::t_out_word)-1){1'b0}}, 1'b1};
            end
        end
    end

    a_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> ($past(r_state) == S_RD))
        else $error("frame write without a read the cycle before");

    a_pend_in_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_state == S_FRD || r_state == S_FCMP || r_state == S_FEND))
        else $error("held row outside a flush");

    a_notlast_has_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_out.last) |-> r_pend_v)
        else $error("non-final row out with nothing held behind it");

    a_shown_only_in_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_wr |-> (r_state == S_FCMP && !f_wr))
        else $error("shown copy written outside compare");

endmodule
